/* rtl/imrt_pkg.sv */
// Package: shared constants and types for the interval map range table.
`default_nettype none
package imrt_pkg;
  localparam int CAPACITY_DEF   = 16;
  localparam int KEY_BITS_DEF   = 16;
  localparam int VALUE_BITS_DEF = 8;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_ASSIGN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_DONE
  } imrt_state_t;
endpackage
`default_nettype wire

/* rtl/imrt_if.sv */
// Interfaces: input item, result item and configuration write channels.
`default_nettype none
interface imrt_in_if #(parameter int KEY_BITS = 16, parameter int VALUE_BITS = 8);
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [KEY_BITS-1:0]   key_begin;
  logic [KEY_BITS:0]     key_end;
  logic [VALUE_BITS-1:0] value;
  modport source (output valid, mode, key_begin, key_end, value, input ready);
  modport sink   (input valid, mode, key_begin, key_end, value, output ready);
endinterface

interface imrt_out_if #(parameter int VALUE_BITS = 8);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] read_value;
  logic                  table_full;
  logic                  empty_range;
  modport source (output valid, read_value, table_full, empty_range, input ready);
  modport sink   (input valid, read_value, table_full, empty_range, output ready);
endinterface

interface imrt_cfg_if #(parameter int VALUE_BITS = 8);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

/* rtl/interval_map_range_table.sv */
// Interval map range table: sorted breakpoint table with range assign and lookup.
//
// Channels: in_ (mode, key_begin, key_end, value), out_ (read_value,
// table_full, empty_range) and cfg_ (default_value write data). Each beat
// moves when valid and ready are both high.
// One item at a time: the block drops in_ready while it works and raises it
// again once the result has been taken by the receiver.
// A lookup scans the table entry by entry through the single read port of
// the key and value rams, then registers the result on out_.
// An assign scans the same way to find the insert position, end position and
// the value at key_end, then rebuilds the table in place in the same rams:
// each moved entry is read and then written at its new place, and one or two
// new breakpoints are written last.
// An assign with an empty range answers in the cycle after its beat.
// A result stays on out_ until taken; a stalled receiver holds the block.
// in_ready returns in the cycle after the result beat.
// Reset empties the table (count to zero) and sets default_value to zero;
// entries hold no reset value and no clearing pass is needed.
// cfg_ writes are taken at any time and meant for idle periods only.
`default_nettype none
module interval_map_range_table
  import imrt_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  imrt_in_if.sink   in_ch,
  imrt_out_if.source out_ch,
  imrt_cfg_if.sink  cfg_ch
);
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 3);
  localparam logic [KEY_BITS:0] KEY_TOP = {1'b1, {KEY_BITS{1'b0}}};

  imrt_state_t state_r, state_nxt;

  logic [VALUE_BITS-1:0] def_r;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic                  mode_r, mode_nxt;
  logic [KEY_BITS-1:0]   kb_r, kb_nxt;
  logic [KEY_BITS:0]     ke_r, ke_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  // scan results
  logic [CW-1:0]         lo_r, lo_nxt;     // first index with key >= kb
  logic [CW-1:0]         hi_r, hi_nxt;     // first index with key >= ke
  logic                  endp_r, endp_nxt; // breakpoint sits exactly at ke
  logic [VALUE_BITS-1:0] vkb_r, vkb_nxt;   // value at kb
  logic [VALUE_BITS-1:0] vke_r, vke_nxt;   // value at ke
  logic [CW-1:0]         ncnt_r, ncnt_nxt;
  logic                  odd_r, odd_nxt;   // rebuild phase: read issued
  logic                  ovld_r, ovld_nxt;
  logic [VALUE_BITS-1:0] ord_r, ord_nxt;
  logic                  ofull_r, ofull_nxt, oempty_r, oempty_nxt;

  // storage: key and value rams
  logic                  we;
  logic [IW-1:0]         waddr, raddr;
  logic [KEY_BITS-1:0]   wkey, rkey;
  logic [VALUE_BITS-1:0] wval, rval;

  imrt_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_keys (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wkey), .raddr(raddr), .rdata(rkey));
  imrt_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_vals (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wval), .raddr(raddr), .rdata(rval));

  // the rebuild walks from the top down when the table grows and up when it
  // shrinks, so a source entry is never overwritten before it is read
  logic                grow;
  logic signed [CW+1:0] delta;
  logic [CW-1:0]        rd_idx_r, rd_idx_nxt; // index whose data sits on rkey/rval
  logic                 rd_vld_r, rd_vld_nxt;

  assign in_ch.ready  = (state_r == ST_IDLE) && !ovld_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ovld_r;
  assign out_ch.read_value  = ord_r;
  assign out_ch.table_full  = ofull_r;
  assign out_ch.empty_range = oempty_r;

  // shift amount between old and new positions of entries at/above hi
  always_comb begin
    delta = (CW+2)'($signed({2'b00, lo_r}) + 1 + ((ke_r < KEY_TOP && !endp_r) ? 1 : 0)
            - $signed({2'b00, hi_r}));
    grow = (delta > 0);
  end

  logic [CW-1:0] ins_end;   // new index after inserted run (first moved entry)
  assign ins_end = lo_r + 1'b1 + CW'((ke_r < KEY_TOP && !endp_r) ? 1 : 0);

  // target index of source entry s (s >= hi)
  function automatic logic [CW-1:0] tgt(input logic [CW-1:0] s,
                                        input logic [CW-1:0] h,
                                        input logic [CW-1:0] e);
    tgt = s - h + e;
  endfunction

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; idx_nxt = idx_r; mode_nxt = mode_r;
    kb_nxt = kb_r; ke_nxt = ke_r; val_nxt = val_r;
    lo_nxt = lo_r; hi_nxt = hi_r; endp_nxt = endp_r;
    vkb_nxt = vkb_r; vke_nxt = vke_r; ncnt_nxt = ncnt_r; odd_nxt = odd_r;
    ovld_nxt = ovld_r; ord_nxt = ord_r; ofull_nxt = ofull_r; oempty_nxt = oempty_r;
    rd_idx_nxt = rd_idx_r; rd_vld_nxt = 1'b0;
    we = 1'b0; waddr = '0; wkey = rkey; wval = rval; raddr = '0;
    if (ovld_r && out_ch.ready) ovld_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          mode_nxt = in_ch.mode;
          kb_nxt   = in_ch.key_begin;
          ke_nxt   = in_ch.key_end;
          val_nxt  = in_ch.value;
          idx_nxt  = '0;
          lo_nxt   = cnt_r; hi_nxt = cnt_r; endp_nxt = 1'b0;
          vkb_nxt  = def_r; vke_nxt = def_r;
          if (in_ch.mode == MODE_ASSIGN &&
              {1'b0, in_ch.key_begin} >= in_ch.key_end) begin
            ord_nxt = '0; ofull_nxt = 1'b0; oempty_nxt = 1'b1;
            ovld_nxt = 1'b1;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      // one entry per cycle: read issued at idx, compared next cycle
      ST_SCAN: begin
        raddr = idx_r[IW-1:0];
        if (idx_r < cnt_r) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = idx_r;
          idx_nxt = idx_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (rkey <= kb_r) vkb_nxt = rval;
          if ({1'b0, rkey} <= ke_r) vke_nxt = rval;
          if (rkey >= kb_r && lo_r == cnt_r) lo_nxt = rd_idx_r;
          if ({1'b0, rkey} >= ke_r && hi_r == cnt_r) hi_nxt = rd_idx_r;
          if ({1'b0, rkey} == ke_r) endp_nxt = 1'b1;
        end
        if (idx_r >= cnt_r && !rd_vld_r) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (mode_r == MODE_LOOKUP) begin
          ord_nxt = vkb_r; ofull_nxt = 1'b0; oempty_nxt = 1'b0;
          ovld_nxt = 1'b1; state_nxt = ST_DONE;
        end else begin
          ncnt_nxt = CW'($signed({2'b00, cnt_r}) + delta);
          if (ke_r > KEY_TOP) ke_nxt = KEY_TOP;
          if ($signed({2'b00, cnt_r}) + delta > CAPACITY) begin
            ord_nxt = '0; ofull_nxt = 1'b1; oempty_nxt = 1'b0;
            ovld_nxt = 1'b1; state_nxt = ST_DONE;
          end else begin
            // moving run: from cnt-1 down to hi when growing, hi up otherwise
            idx_nxt = grow ? cnt_r - 1'b1 : hi_r;
            odd_nxt = 1'b0;
            state_nxt = ST_SHIFT;
          end
        end
      end
      // read entry, then write it at its new place; then fill inserted run
      ST_SHIFT: begin
        if ((grow && (idx_r >= hi_r) && (idx_r < cnt_r)) ||
            (!grow && (idx_r < cnt_r))) begin
          if (!odd_r) begin
            raddr = idx_r[IW-1:0];
            odd_nxt = 1'b1;
          end else begin
            we = 1'b1;
            waddr = IW'(tgt(idx_r, hi_r, ins_end));
            odd_nxt = 1'b0;
            idx_nxt = grow ? idx_r - 1'b1 : idx_r + 1'b1;
          end
        end else begin
          // moved entries done: write kb, then ke breakpoint
          if (!odd_r) begin
            we = 1'b1; waddr = IW'(lo_r); wkey = kb_r; wval = val_r;
            odd_nxt = 1'b1;
            if (!(ke_r < KEY_TOP && !endp_r)) begin
              cnt_nxt = ncnt_r;
              ord_nxt = '0; ofull_nxt = 1'b0; oempty_nxt = 1'b0;
              ovld_nxt = 1'b1; state_nxt = ST_DONE;
            end
          end else begin
            we = 1'b1; waddr = IW'(lo_r + 1'b1);
            wkey = ke_r[KEY_BITS-1:0]; wval = vke_r;
            cnt_nxt = ncnt_r;
            ord_nxt = '0; ofull_nxt = 1'b0; oempty_nxt = 1'b0;
            ovld_nxt = 1'b1; state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!ovld_r || out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      def_r   <= '0;
      ovld_r  <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovld_r  <= ovld_nxt;
      rd_vld_r <= rd_vld_nxt;
      if (cfg_ch.valid) def_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt; mode_r <= mode_nxt; kb_r <= kb_nxt; ke_r <= ke_nxt;
    val_r <= val_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt; endp_r <= endp_nxt;
    vkb_r <= vkb_nxt; vke_r <= vke_nxt; ncnt_r <= ncnt_nxt; odd_r <= odd_nxt;
    ord_r <= ord_nxt; ofull_r <= ofull_nxt; oempty_r <= oempty_nxt;
    rd_idx_r <= rd_idx_nxt;
  end

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY)) else $error("breakpoint count above capacity");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r |-> !(ofull_r && oempty_r)) else $error("both flags set");
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> (cnt_r == $past(cnt_r))) else $error("count moved in scan");
endmodule

// Simple dual-port RAM: one write port, one read port with registered data.
module imrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* tb/sv/interval_map_range_table_tb.sv */
// Testbench for the interval map range table: directed and random range assigns and lookups.
module interval_map_range_table_tb
  import imrt_pkg::*;
;

  typedef struct packed {
    logic [7:0] read_value;
    logic       table_full;
    logic       empty_range;
  } imrt_result_t;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   sender_idle_pct;
  int   receiver_stall_pct;
  int   hold_off_cycles;

  imrt_in_if  #(.KEY_BITS(16), .VALUE_BITS(8)) in_ch ();
  imrt_out_if #(.VALUE_BITS(8)) out_ch ();
  imrt_cfg_if #(.VALUE_BITS(8)) cfg_ch ();

  interval_map_range_table dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // predictor state
  logic [7:0]  shadow_default;
  logic [15:0] shadow_keys[16];
  logic [7:0]  shadow_values[16];
  int          shadow_count;
  imrt_result_t expected_results[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("interval_map_range_table_tb: errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  function automatic logic [7:0] value_of_key(input logic [16:0] key);
    logic [7:0] v;
    v = shadow_default;
    for (int i = 0; i < shadow_count; i++) begin
      if ({1'b0, shadow_keys[i]} <= key) v = shadow_values[i];
      else break;
    end
    return v;
  endfunction

  function automatic imrt_result_t predict_range_op(input logic mode, input logic [15:0] kb,
                                                    input logic [16:0] ke_in,
                                                    input logic [7:0] val);
    imrt_result_t r;
    logic [16:0] ke;
    logic [15:0] nk[18];
    logic [7:0]  nv[18];
    logic [7:0]  end_val;
    int n;
    int i;
    bit overflow;
    r = '0;
    n = 0;
    i = 0;
    overflow = 0;
    if (mode == MODE_LOOKUP) begin
      r.read_value = value_of_key({1'b0, kb});
      return r;
    end
    ke = (ke_in > 17'h10000) ? 17'h10000 : ke_in;
    if ({1'b0, kb} >= ke) begin
      r.empty_range = 1'b1;
      return r;
    end
    end_val = value_of_key(ke);
    while (i < shadow_count && shadow_keys[i] < kb) begin
      nk[n] = shadow_keys[i]; nv[n] = shadow_values[i]; n++; i++;
    end
    nk[n] = kb; nv[n] = val; n++;
    while (i < shadow_count && {1'b0, shadow_keys[i]} < ke) i++;
    if (ke < 17'h10000 && !(i < shadow_count && {1'b0, shadow_keys[i]} == ke)) begin
      nk[n] = ke[15:0]; nv[n] = end_val; n++;
    end
    for (; i < shadow_count; i++) begin
      if (n >= 18) begin
        overflow = 1;
        break;
      end
      nk[n] = shadow_keys[i]; nv[n] = shadow_values[i]; n++;
    end
    if (overflow || n > 16) begin
      r.table_full = 1'b1;
      return r;
    end
    for (int j = 0; j < n; j++) begin
      shadow_keys[j] = nk[j]; shadow_values[j] = nv[j];
    end
    shadow_count = n;
    return r;
  endfunction

  // receiver and checker
  initial begin
    imrt_result_t got;
    imrt_result_t want;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.read_value, out_ch.table_full, out_ch.empty_range};
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.read_value !== want.read_value)
            report_mismatch("read_value", got.read_value, want.read_value);
          if (got.table_full !== want.table_full)
            report_mismatch("table_full", got.table_full, want.table_full);
          if (got.empty_range !== want.empty_range)
            report_mismatch("empty_range", got.empty_range, want.empty_range);
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // the block is never ready in the cycle after a beat, so the task first waits
  // for a clock edge; this loses nothing and keeps valid from being driven twice at one edge
  task automatic send_item(input logic mode, input logic [15:0] kb, input logic [16:0] ke,
                           input logic [7:0] val);
    @(posedge clk);
    while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= mode;
    in_ch.key_begin <= kb;
    in_ch.key_end   <= ke;
    in_ch.value     <= val;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(predict_range_op(mode, kb, ke, val));
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    while (expected_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (50) @(posedge clk);
  endtask

  task automatic write_default(input logic [7:0] d);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    shadow_default = d;
  endtask

  task automatic random_item(input bit small_keys);
    logic [15:0] kb;
    logic [16:0] ke;
    int pick;
    pick = $urandom_range(99);
    kb = small_keys ? 16'($urandom_range(40)) : 16'($urandom);
    if (pick < 10) ke = 17'($urandom_range(17'h1FFFF, 17'h10000));
    else if (pick < 20) ke = {1'b0, 16'($urandom)};
    else ke = 17'(kb) + 17'($urandom_range(small_keys ? 8 : 3000));
    send_item($urandom_range(99) < 55 ? MODE_ASSIGN : MODE_LOOKUP, kb, ke, 8'($urandom));
  endtask

  task automatic test_directed();
    send_item(MODE_LOOKUP, 16'h0000, 17'h0, 8'h00);
    send_item(MODE_LOOKUP, 16'hFFFF, 17'h1FFFF, 8'hFF);
    send_item(MODE_ASSIGN, 16'h0010, 17'h0010, 8'hAA);   // empty range, begin equals end
    send_item(MODE_ASSIGN, 16'h0020, 17'h0010, 8'hAA);   // begin above end
    send_item(MODE_ASSIGN, 16'h0000, 17'h1FFFF, 8'hFF);  // end clipped to the top
    send_item(MODE_LOOKUP, 16'hFFFF, 17'h0, 8'h00);
    send_item(MODE_ASSIGN, 16'h1000, 17'h2000, 8'h55);
    send_item(MODE_ASSIGN, 16'h1800, 17'h2800, 8'h33);
    send_item(MODE_LOOKUP, 16'h17FF, 17'h0, 8'h00);
    send_item(MODE_LOOKUP, 16'h2000, 17'h0, 8'h00);
    send_item(MODE_LOOKUP, 16'h2800, 17'h0, 8'h00);
    send_item(MODE_ASSIGN, 16'hFFFF, 17'h10000, 8'h01);
    send_item(MODE_ASSIGN, 16'h0000, 17'h10000, 8'h00);  // wipe down to one breakpoint
    // overflow: many disjoint small ranges
    for (int i = 0; i < 10; i++)
      send_item(MODE_ASSIGN, 16'(i * 16 + 4), 17'(i * 16 + 8), 8'(i + 1));
    send_item(MODE_LOOKUP, 16'h0005, 17'h0, 8'h00);
  endtask

  task automatic test_default_change();
    write_default(8'hFF);
    send_item(MODE_ASSIGN, 16'h0000, 17'h0, 8'h00);
    send_item(MODE_ASSIGN, 16'h0100, 17'h0200, 8'h7E);
    write_default(8'hFF);
    send_item(MODE_LOOKUP, 16'h0000, 17'h0, 8'h00);
    write_default(8'h00);
    send_item(MODE_LOOKUP, 16'h0000, 17'h0, 8'h00);
  endtask

  task automatic test_random_phase(input int n, input int idle_pct, input int stall_pct);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) random_item($urandom_range(99) < 70);
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off_cycles = 300;
    for (int i = 0; i < 20; i++) random_item(1'b1);
    drain_results();  // sender pauses until everything is back
    for (int i = 0; i < 10; i++) random_item(1'b1);
  endtask

  initial begin
    mismatches = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off_cycles = 0;
    shadow_default = 8'h00;
    shadow_count = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_LOOKUP;
    in_ch.key_begin = '0;
    in_ch.key_end = '0;
    in_ch.value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_default_change();
    test_random_phase(120, 0, 0);
    write_default(8'h5A);
    test_random_phase(120, 87, 0);
    write_default(8'h00);
    test_random_phase(120, 0, 87);
    write_default(8'hA5);
    test_random_phase(110, 33, 33);
    test_backpressure();
    drain_results();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("interval_map_range_table_tb: clean");
    end else begin
      $display("interval_map_range_table_tb: errors");
    end
    $finish;
  end
endmodule
